// ----- design/tfcc_pkg.sv -----
package tfcc_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_MULTIPLIER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_OFFSET     = 1'b1;

    localparam logic [8:0]  MULT_RESET   = 9'd175;
    localparam logic [7:0]  OFFSET_RESET = 8'd45;

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [7:0]  CRC_INIT     = 8'hFF;
    localparam logic [7:0]  CRC_XOR_OUT  = 8'h00;

    localparam logic [16:0] RAW_FULL     = 17'd65535;

    localparam logic [1:0]  POS_HIGH = 2'd0;
    localparam logic [1:0]  POS_LOW  = 2'd1;
    localparam logic [1:0]  POS_CRC  = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_first;
    } t_in_word;

    typedef struct packed {
        logic signed [18:0] temperature_fx;
        logic [15:0]        raw_reading;
        logic               frame_status;
    } t_out_word;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/temp_frame_crc_check_convert_top.sv -----
// Checks and converts three-byte temperature sensor replies: high data byte, low data byte,
// then a CRC-8 (polynomial 0x31, start 0xFF, no final xor). A word with frame_first set
// always starts a new reply. On the CRC byte one result word comes out: the raw reading,
// a status bit (1 on CRC mismatch) and, when the CRC matches, the temperature in
// 1/512 degree as floor(512*multiplier*raw/65535) - 512*offset, wrapped to 19 bits;
// 0 on mismatch. One byte is taken every clock cycle while o_in_stall is low. The path is
// three registers deep (input register, CRC and multiply stage, divide-and-offset output
// register), which each result passes through in that order; empty stages close up, so
// bytes keep flowing while a result waits. Scale registers may only be written while idle.
module temp_frame_crc_check_convert_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [tfcc_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [tfcc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  tfcc_pkg::t_in_word                      i_in_word,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output tfcc_pkg::t_out_word                     o_out_word
);
    import tfcc_pkg::*;

    logic [8:0]  r_mult;
    logic [7:0]  r_off;

    logic        r_a_valid;
    t_in_word    r_a_word;

    logic [1:0]  r_pos,  n_pos;
    logic [7:0]  r_crc,  n_crc;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low,  n_low;

    logic        r_b_valid, n_b_valid;
    logic [24:0] r_b_prod,  n_b_prod;
    logic [15:0] r_b_raw,   n_b_raw;
    logic        r_b_err,   n_b_err;

    logic        r_c_valid;
    t_out_word   r_c_word, n_c_word;

    logic        en_a, en_b, en_c;
    logic [1:0]  pos;
    logic [15:0] raw;

    logic [33:0] x;
    logic [17:0] q0;
    logic [18:0] r0;
    logic [2:0]  q1;
    logic [16:0] r1;
    logic        corr;
    logic [17:0] quot;
    logic [18:0] temp;

    assign en_c = !r_c_valid || !i_out_stall;
    assign en_b = !r_b_valid || en_c;
    assign en_a = !r_a_valid || en_b;

    assign o_in_stall  = !en_a;
    assign o_out_valid = r_c_valid;
    assign o_out_word  = r_c_word;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_RESET;
            r_off  <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_MULTIPLIER: r_mult <= i_cfg_data;
                CFG_SCALE_OFFSET:     r_off  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_word <= i_in_word;
        end
    end

    // frame tracking, crc and multiply
    assign pos = r_a_word.frame_first ? POS_HIGH : r_pos;
    assign raw = {r_high, r_low};

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_high    = r_high;
        n_low     = r_low;
        n_b_valid = 1'b0;
        n_b_prod  = 25'(r_mult) * 25'(raw);
        n_b_raw   = raw;
        n_b_err   = ((r_crc ^ CRC_XOR_OUT) != r_a_word.rx_byte);
        case (pos)
            POS_LOW: begin
                n_low = r_a_word.rx_byte;
                n_crc = crc8_update(r_crc, r_a_word.rx_byte);
                n_pos = POS_CRC;
            end
            POS_CRC: begin
                n_b_valid = 1'b1;
                n_crc     = CRC_INIT;
                n_pos     = POS_HIGH;
            end
            default: begin
                n_high = r_a_word.rx_byte;
                n_crc  = crc8_update(CRC_INIT, r_a_word.rx_byte);
                n_pos  = POS_LOW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_HIGH;
            r_crc     <= CRC_INIT;
            r_high    <= 8'd0;
            r_low     <= 8'd0;
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid && n_b_valid;
            if (r_a_valid) begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_high <= n_high;
                r_low  <= n_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid && n_b_valid) begin
            r_b_prod <= n_b_prod;
            r_b_raw  <= n_b_raw;
            r_b_err  <= n_b_err;
        end
    end

    // divide by 65535 via end-around folding, then remove the offset
    assign x    = {r_b_prod, 9'd0};
    assign q0   = x[33:16];
    assign r0   = {3'd0, x[15:0]} + {1'b0, q0};
    assign q1   = r0[18:16];
    assign r1   = {1'b0, r0[15:0]} + {14'd0, q1};
    assign corr = (r1 >= RAW_FULL);
    assign quot = q0 + {15'd0, q1} + {17'd0, corr};
    assign temp = {1'b0, quot} - {2'b0, r_off, 9'd0};

    always_comb begin
        n_c_word.temperature_fx = r_b_err ? 19'sd0 : $signed(temp);
        n_c_word.raw_reading    = r_b_raw;
        n_c_word.frame_status   = r_b_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_valid) begin
            r_c_word <= n_c_word;
        end
    end

endmodule

// ----- bench/temp_frame_crc_check_convert_top_tb.sv -----
module temp_frame_crc_check_convert_top_tb;
    import tfcc_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_word               i_in_word;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_word              o_out_word;

    // decoder state as the sensor reply is seen from outside
    logic [8:0] exp_mult;
    logic [7:0] exp_offset;
    logic [1:0] frame_pos;
    logic [7:0] hi_data;
    logic [7:0] lo_data;
    logic [7:0] crc_acc;

    t_out_word expected_readings[$];
    t_out_word want;
    int        fail_count;
    bit        calm;

    temp_frame_crc_check_convert_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // bit-serial crc, msb first
    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [18:0] scaled_temperature(input logic [15:0] raw);
        longint unsigned scaled;
        longint unsigned off;
        longint unsigned diff;
        scaled = (64'd512 * exp_mult * raw) / 64'd65535;
        off    = 64'd512 * exp_offset;
        diff   = scaled - off;
        return diff[18:0];
    endfunction

    function automatic void decode_word(input logic [7:0] data, input logic first);
        t_out_word r;
        logic [1:0] pos;
        pos = first ? POS_HIGH : frame_pos;
        case (pos)
            POS_LOW: begin
                lo_data   = data;
                crc_acc   = crc_next(crc_acc, data);
                frame_pos = POS_CRC;
            end
            POS_CRC: begin
                r.raw_reading    = {hi_data, lo_data};
                r.frame_status   = (crc_acc ^ CRC_XOR_OUT) != data;
                r.temperature_fx = r.frame_status ? '0 : scaled_temperature(r.raw_reading);
                expected_readings.push_back(r);
                frame_pos = POS_HIGH;
                crc_acc   = CRC_INIT;
            end
            default: begin
                hi_data   = data;
                crc_acc   = crc_next(CRC_INIT, data);
                frame_pos = POS_LOW;
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_data();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_word(input logic [7:0] data, input logic first);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 3) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_word.rx_byte     = data;
        i_in_word.frame_first = first;
        i_in_valid            = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        decode_word(data, first);
    endtask

    task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                              input logic first, input bit crc_good);
        logic [7:0] crc;
        crc = crc_next(crc_next(CRC_INIT, hi), lo);
        if (!crc_good)
            crc = crc ^ 8'($urandom_range(1, 255));
        send_word(hi, first);
        send_word(lo, 1'b0);
        send_word(crc, 1'b0);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [8:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_SCALE_MULTIPLIER)
            exp_mult = value;
        else
            exp_offset = value[7:0];
    endtask

    task automatic set_scale(input logic [8:0] mult, input logic [7:0] offset);
        write_reg(CFG_SCALE_MULTIPLIER, mult);
        write_reg(CFG_SCALE_OFFSET, {1'b0, offset});
    endtask

    task automatic test_reset_scale();
        send_frame(8'h00, 8'h00, 1'b1, 1'b1);
        send_frame(8'hFF, 8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_crc_mismatch();
        send_frame(8'hFF, 8'hFF, 1'b1, 1'b0);
    endtask

    task automatic test_resync();
        send_word(8'h12, 1'b1);
        send_word(8'h34, 1'b0);
        send_frame(8'h66, 8'hA3, 1'b1, 1'b1);
        send_word(8'h56, 1'b1);
        send_frame(8'h9C, 8'h01, 1'b1, 1'b1);
    endtask

    task automatic test_missing_mark();
        send_frame(8'h80, 8'h7F, 1'b0, 1'b1);
    endtask

    task automatic test_drain_pause();
        repeat (4) send_frame(pick_data(), pick_data(), 1'b1, 1'b1);
        drain();
        repeat (4) send_frame(pick_data(), pick_data(), 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [8:0] mults[8]   = '{9'd175, 9'd511, 9'd0, 9'd1, 9'd315, 9'd511, 9'd0, 9'd0};
        logic [7:0] offsets[8] = '{8'd45, 8'd255, 8'd0, 8'd0, 8'd49, 8'd0, 8'd255, 8'd0};
        int         pick;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7)
                set_scale(9'($urandom_range(1, 511)), 8'($urandom_range(255)));
            else
                set_scale(mults[ph], offsets[ph]);
            calm = (ph == 3);
            for (int n = 0; n < 56; n++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    send_frame(pick_data(), pick_data(), 1'b1, 1'b1);
                else if (pick < 78)
                    send_frame(pick_data(), pick_data(), 1'b0, 1'b1);
                else if (pick < 88)
                    send_frame(pick_data(), pick_data(), 1'($urandom_range(1)), 1'b0);
                else if (pick < 94)
                    send_word(pick_data(), 1'($urandom_range(1)));
                else begin
                    // broken reply, cut short
                    send_word(pick_data(), 1'b1);
                    if ($urandom_range(1))
                        send_word(pick_data(), 1'b0);
                end
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = !calm && ($urandom_range(99) < 10);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                fail_count++;
                $display("%0t unexpected word: expected none, actual %h", $time, o_out_word);
            end else begin
                want = expected_readings.pop_front();
                if (o_out_word.temperature_fx !== want.temperature_fx) begin
                    fail_count++;
                    $display("%0t temperature_fx: expected %0d, actual %0d", $time,
                             $signed(want.temperature_fx), $signed(o_out_word.temperature_fx));
                end
                if (o_out_word.raw_reading !== want.raw_reading) begin
                    fail_count++;
                    $display("%0t raw_reading: expected %h, actual %h", $time,
                             want.raw_reading, o_out_word.raw_reading);
                end
                if (o_out_word.frame_status !== want.frame_status) begin
                    fail_count++;
                    $display("%0t frame_status: expected %b, actual %b", $time,
                             want.frame_status, o_out_word.frame_status);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        fail_count  = 0;
        calm        = 1'b0;
        exp_mult    = MULT_RESET;
        exp_offset  = OFFSET_RESET;
        frame_pos   = POS_HIGH;
        hi_data     = 8'h00;
        lo_data     = 8'h00;
        crc_acc     = CRC_INIT;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_scale();
        test_crc_mismatch();
        test_resync();
        test_missing_mark();
        test_drain_pause();
        test_random_traffic();

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
